@@ rtl/core/rsmc_pkg.sv @@
// rsmc_pkg: types and constants shared by the steering mode controller core
// no dependencies

package rsmc_pkg;

	// signed working width for sensor samples and their differences
	localparam int CALC_BITS = 18;

	// divide by 15 through a reciprocal, exact below the throttle saturation point
	localparam int           RECIP15_SHIFT  = 16;
	localparam logic [12:0]  RECIP15        = 13'd4370;
	localparam int           THR_FULL_FRONT = 2445;

	// two fifths as 410 / 1024, exact for quotients below 163
	localparam logic [9:0]   TWO_FIFTHS       = 10'd410;
	localparam int           TWO_FIFTHS_SHIFT = 10;

	localparam logic signed [7:0] THR_BASE_OFS = 8'sd35;
	localparam logic signed [7:0] THR_MAX      = 8'sd100;
	localparam logic signed [7:0] THR_BRAKE    = -8'sd10;
	localparam logic signed [7:0] THR_STUCK    = -8'sd50;
	localparam logic signed [7:0] THR_CURVE    = 8'sd55;

	localparam logic [6:0] STEER_CENTRE = 7'd50;

	typedef enum logic [2:0] {
		MODE_FORWARD = 3'd1,
		MODE_LEFT    = 3'd3,
		MODE_RIGHT   = 3'd4,
		MODE_STUCK   = 3'd5,
		MODE_DOUBLE  = 3'd6,
		MODE_SPIN    = 3'd7
	} drive_mode_t;

	typedef enum logic [1:0] {
		CFG_TURN_DIR      = 2'd0,
		CFG_CURVE_HOLD    = 2'd1,
		CFG_STUCK_TIMEOUT = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic       turn_direction;
		logic [7:0] curve_hold_ticks;
		logic [5:0] stuck_timeout;
	} cfg_t;

	// per-beat side information carried beside the distance samples
	typedef struct packed {
		logic [15:0] speed;
		logic [7:0]  quot;
		logic        thr_sat;
	} sample_t;

endpackage

@@ rtl/core/rsmc_cfg_regs.sv @@
// rsmc_cfg_regs: configuration register file of the steering mode controller
// depends on rsmc_pkg

module rsmc_cfg_regs import rsmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_direction   <= 1'b0;
			cfg_q.curve_hold_ticks <= 8'd15;
			cfg_q.stuck_timeout    <= 6'd60;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_TURN_DIR:      cfg_q.turn_direction   <= cfg_data[0];
				CFG_CURVE_HOLD:    cfg_q.curve_hold_ticks <= cfg_data;
				CFG_STUCK_TIMEOUT: cfg_q.stuck_timeout    <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/rsmc_in_stage.sv @@
// rsmc_in_stage: input register of the steering mode controller
// also forms front / 15 ahead of the register; depends on rsmc_pkg

module rsmc_in_stage import rsmc_pkg::*; #(
	parameter int SENSOR_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SENSOR_BITS-1:0] front_distance,
	input  logic [SENSOR_BITS-1:0] left_distance,
	input  logic [SENSOR_BITS-1:0] right_distance,
	input  logic [15:0]            measured_speed,
	input  logic                   advance,
	output logic                   valid_s1,
	output logic [SENSOR_BITS-1:0] front_s1,
	output logic [SENSOR_BITS-1:0] left_s1,
	output logic [SENSOR_BITS-1:0] right_s1,
	output sample_t                smp_s1
);

	logic [CALC_BITS-1:0] front_ext;
	logic [11:0]          front_lo;
	logic [24:0]          recip_prod;
	logic                 load;
	sample_t              smp;

	assign front_ext  = {{(CALC_BITS-SENSOR_BITS){1'b0}}, front_distance};
	assign front_lo   = front_ext[11:0];
	assign recip_prod = 25'(front_lo) * 25'(RECIP15);

	always_comb begin
		smp.speed   = measured_speed;
		smp.quot    = recip_prod[RECIP15_SHIFT +: 8];
		smp.thr_sat = (front_ext >= CALC_BITS'(THR_FULL_FRONT));
	end

	assign sample_stall = valid_s1 && !advance;
	assign load         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			front_s1 <= front_distance;
			left_s1  <= left_distance;
			right_s1 <= right_distance;
			smp_s1   <= smp;
		end
	end

endmodule

@@ rtl/core/rsmc_mode_ctrl.sv @@
// rsmc_mode_ctrl: driving mode machine, tick counters and steer / throttle forming
// depends on rsmc_pkg

module rsmc_mode_ctrl import rsmc_pkg::*; #(
	parameter int SENSOR_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  cfg_t                   cfg,
	input  logic [SENSOR_BITS-1:0] front,
	input  logic [SENSOR_BITS-1:0] left,
	input  logic [SENSOR_BITS-1:0] right,
	input  sample_t                smp,
	output logic [6:0]             steer,
	output logic signed [7:0]      throttle
);

	localparam int PAD = CALC_BITS - SENSOR_BITS;

	drive_mode_t mode_q, mode_d, mode_a, mode_b;
	logic [SENSOR_BITS-1:0] prev_front_q, prev_left_q, prev_right_q;
	logic [6:0] stuck_q, stuck_d, st1, st2;
	logic [7:0] lc_q, lc_d, rc_q, rc_d, dt_q, dt_d, spin_q, spin_d;
	logic [7:0] limit_q, limit_d;
	logic [6:0] last_steer_q;

	logic signed [CALC_BITS-1:0] f_x, l_x, r_x, pf_x, pl_x, pr_x;
	logic signed [CALC_BITS-1:0] lr, lr_sh, dl, dr, df, steer_w;
	logic [17:0] mulq;
	logic signed [7:0] thr_base, thr_w;
	logic slow, blocked, timeout, brake, ccw;

	assign f_x  = signed'({{PAD{1'b0}}, front});
	assign l_x  = signed'({{PAD{1'b0}}, left});
	assign r_x  = signed'({{PAD{1'b0}}, right});
	assign pf_x = signed'({{PAD{1'b0}}, prev_front_q});
	assign pl_x = signed'({{PAD{1'b0}}, prev_left_q});
	assign pr_x = signed'({{PAD{1'b0}}, prev_right_q});

	assign lr    = l_x - r_x;
	assign lr_sh = lr >>> 5;
	assign dl    = l_x - pl_x;
	assign dr    = r_x - pr_x;
	assign df    = f_x - pf_x;
	assign ccw   = cfg.turn_direction;

	assign mulq     = 18'(smp.quot) * 18'(TWO_FIFTHS);
	assign thr_base = smp.thr_sat ? THR_MAX
		: THR_BASE_OFS + signed'({1'b0, mulq[TWO_FIFTHS_SHIFT +: 7]});

	// stuck detection
	assign slow    = (smp.speed <= 16'd1);
	assign st1     = stuck_q + 7'd1;
	assign st2     = slow ? st1 + 7'd1 : st1;
	assign blocked = (f_x <= 18'sd60) && ((l_x <= 18'sd60) || (r_x <= 18'sd60))
		&& (smp.speed <= 16'd1000);
	assign mode_a  = blocked ? MODE_STUCK : mode_q;
	assign timeout = (st2 >= {1'b0, cfg.stuck_timeout});
	assign stuck_d = timeout ? 7'd0 : st2;
	assign mode_b  = timeout ? MODE_STUCK : mode_a;
	assign brake   = (mode_b == MODE_FORWARD) && (df < 0) && (smp.speed > 16'd1500);

	always_comb begin
		mode_d  = mode_b;
		lc_d    = lc_q;
		rc_d    = rc_q;
		dt_d    = dt_q;
		spin_d  = spin_q;
		limit_d = limit_q;
		steer_w = signed'(CALC_BITS'(last_steer_q));
		thr_w   = thr_base;
		if (brake) begin
			thr_w = THR_BRAKE;
		end else begin
			case (mode_b)
				MODE_FORWARD: begin
					lc_d    = 8'd0;
					rc_d    = 8'd0;
					dt_d    = 8'd0;
					spin_d  = 8'd0;
					limit_d = 8'd1;
					steer_w = signed'(CALC_BITS'(STEER_CENTRE)) - lr_sh;
					if (f_x > 18'sd1300 && l_x > 18'sd700 && dl > 18'sd300 && ccw) begin
						mode_d = MODE_DOUBLE;
					end else if (f_x > 18'sd1000 && r_x > 18'sd650 && dr > 18'sd200
						&& ccw) begin
						mode_d = MODE_SPIN;
					end else if (dl >= 18'sd450 && l_x >= 18'sd1200 && f_x < 18'sd600
						&& r_x <= 18'sd800) begin
						limit_d = cfg.curve_hold_ticks;
						mode_d  = MODE_LEFT;
					end else if (dr >= 18'sd450 && r_x >= 18'sd1000 && l_x <= 18'sd800
						&& f_x < 18'sd600) begin
						limit_d = cfg.curve_hold_ticks;
						mode_d  = MODE_RIGHT;
					end
				end
				MODE_LEFT: begin
					lc_d    = lc_q + 8'd1;
					thr_w   = THR_CURVE;
					steer_w = 18'sd35;
					if (f_x > l_x && lc_d >= limit_q) begin
						mode_d = MODE_FORWARD;
					end
				end
				MODE_RIGHT: begin
					rc_d    = rc_q + 8'd1;
					thr_w   = THR_CURVE;
					steer_w = 18'sd75;
					if (f_x > r_x && rc_d >= limit_q) begin
						mode_d = MODE_FORWARD;
					end
				end
				MODE_STUCK: begin
					thr_w = THR_STUCK;
					if (l_x < r_x) begin
						steer_w = 18'sd0;
					end else if (r_x < l_x) begin
						steer_w = 18'sd100;
					end else begin
						steer_w = 18'sd40;
					end
					if (f_x >= 18'sd200 && l_x >= 18'sd40 && r_x >= 18'sd40) begin
						mode_d = MODE_FORWARD;
					end
				end
				MODE_DOUBLE: begin
					dt_d = dt_q + 8'd1;
					if (ccw) begin
						if (dt_d <= 8'd10) begin
							thr_w   = -8'sd25;
							steer_w = 18'sd60;
						end else if (dt_d <= 8'd65) begin
							thr_w   = 8'sd45;
							steer_w = 18'sd0;
						end else if (dt_d <= 8'd160) begin
							thr_w   = THR_CURVE;
							steer_w = 18'sd47 - lr_sh;
						end else if (dt_d <= 8'd210) begin
							thr_w   = 8'sd33;
							steer_w = 18'sd100;
						end
						if (dt_d >= 8'd210) begin
							mode_d = MODE_FORWARD;
						end
					end
				end
				MODE_SPIN: begin
					spin_d = spin_q + 8'd1;
					if (ccw) begin
						thr_w = (spin_d <= 8'd15) ? -8'sd20 : 8'sd45;
						if (spin_d <= 8'd55) begin
							steer_w = 18'sd80;
						end else if (spin_d <= 8'd95) begin
							steer_w = 18'sd25;
						end
						if (spin_d >= 8'd95) begin
							mode_d = MODE_FORWARD;
						end
					end
				end
				default: begin
					mode_d = MODE_FORWARD;
				end
			endcase
		end
	end

	// every throttle source already lies inside -100..100
	always_comb begin
		if (steer_w < 0) begin
			steer = 7'd0;
		end else if (steer_w > 18'sd100) begin
			steer = 7'd100;
		end else begin
			steer = steer_w[6:0];
		end
		throttle = thr_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_FORWARD;
			prev_front_q <= '0;
			prev_left_q  <= '0;
			prev_right_q <= '0;
			stuck_q      <= 7'd0;
			lc_q         <= 8'd0;
			rc_q         <= 8'd0;
			dt_q         <= 8'd0;
			spin_q       <= 8'd0;
			limit_q      <= 8'd0;
			last_steer_q <= STEER_CENTRE;
		end else if (step) begin
			mode_q       <= mode_d;
			prev_front_q <= front;
			prev_left_q  <= left;
			prev_right_q <= right;
			stuck_q      <= stuck_d;
			lc_q         <= lc_d;
			rc_q         <= rc_d;
			dt_q         <= dt_d;
			spin_q       <= spin_d;
			limit_q      <= limit_d;
			last_steer_q <= steer;
		end
	end

endmodule

@@ rtl/core/reactive_steering_mode_controller_core.sv @@
// reactive_steering_mode_controller_core: top level of the steering mode controller
// instantiates rsmc_cfg_regs, rsmc_in_stage and rsmc_mode_ctrl; depends on rsmc_pkg
//
// channel   handshake                  beat contents
// sample    sample_valid/sample_stall  front, left, right distance, measured_speed
// result    result_valid/result_stall  steer_percent, throttle_percent
// cfg       cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one beat per cycle sustained while result_stall is low; a result passes the input register, then the result register
// the input register and the result register enclose the combinational mode logic
// asynchronous reset puts cfg and mode state registers to defaults, mode to forward, both stages empty
// result_stall holds the result; sample_stall rises only when both stages are full
// cfg_ready is always high

module reactive_steering_mode_controller_core import rsmc_pkg::*; #(
	parameter int SENSOR_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SENSOR_BITS-1:0] front_distance,
	input  logic [SENSOR_BITS-1:0] left_distance,
	input  logic [SENSOR_BITS-1:0] right_distance,
	input  logic [15:0]            measured_speed,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [6:0]             steer_percent,
	output logic signed [7:0]      throttle_percent,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data
);

	cfg_t                   cfg;
	sample_t                smp_s1;
	logic [SENSOR_BITS-1:0] front_s1, left_s1, right_s1;
	logic                   valid_s1, advance;
	logic [6:0]             steer_d, steer_q;
	logic signed [7:0]      thr_d, thr_q;
	logic                   valid_q;

	assign advance = valid_s1 && (!valid_q || !result_stall);

	rsmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rsmc_in_stage #(.SENSOR_BITS(SENSOR_BITS)) u_in (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.front_distance (front_distance),
		.left_distance  (left_distance),
		.right_distance (right_distance),
		.measured_speed (measured_speed),
		.advance        (advance),
		.valid_s1       (valid_s1),
		.front_s1       (front_s1),
		.left_s1        (left_s1),
		.right_s1       (right_s1),
		.smp_s1         (smp_s1)
	);

	rsmc_mode_ctrl #(.SENSOR_BITS(SENSOR_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cfg      (cfg),
		.front    (front_s1),
		.left     (left_s1),
		.right    (right_s1),
		.smp      (smp_s1),
		.steer    (steer_d),
		.throttle (thr_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			steer_q <= steer_d;
			thr_q   <= thr_d;
		end
	end

	assign result_valid     = valid_q;
	assign steer_percent    = steer_q;
	assign throttle_percent = thr_q;

endmodule

@@ rtl/core/rsmc_checker.sv @@
// rsmc_checker: port-level checks of the steering mode controller core
// bound to reactive_steering_mode_controller_core; no package needed

module rsmc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input logic              result_valid,
	input logic              result_stall,
	input logic [6:0]        steer_percent,
	input logic signed [7:0] throttle_percent
);

	// a held result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(steer_percent)
			&& $stable(throttle_percent))
		else $error("result beat changed while stalled");

	// back pressure only when the result side is full and stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("sample stalled without result back pressure");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> steer_percent <= 7'd100)
		else $error("steer out of range");

	// strongest reverse command is the stuck manoeuvre
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> throttle_percent >= -8'sd50 && throttle_percent <= 8'sd100)
		else $error("throttle out of range");

	// with no result held and no sample beat arriving, the input stage drains and sample_stall is then low
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !sample_valid |=> !sample_stall)
		else $error("stall with both stages draining");

endmodule

bind reactive_steering_mode_controller_core rsmc_checker u_rsmc_checker (.*);
